[src/cgs_pkg.sv]
// ----------------------------------------------------------------------------
// cgs_pkg: shared types and constants of the cost grid sampler
// field widths, stream packing, status and action codes, parameter defaults
// ----------------------------------------------------------------------------
package cgs_pkg;

  // parameter defaults
  localparam int unsigned MAX_DIM_DEF      = 256;
  localparam int unsigned FRAC_BITS_DEF    = 8;
  localparam int unsigned GRAD_SAMPLES_DEF = 3;

  // field widths
  localparam int unsigned CELL_W   = 8;
  localparam int unsigned COORD_W  = 18;
  localparam int unsigned CFG_W    = 9;
  localparam int unsigned COST_W   = 24;
  localparam int unsigned GRAD_W   = 13;
  localparam int unsigned GACC_W   = 14;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned WG_W     = 5;

  // input tdata layout
  localparam int unsigned COL_LSB     = 0;
  localparam int unsigned ROW_LSB     = COL_LSB + CELL_W;
  localparam int unsigned VALUE_LSB   = ROW_LSB + CELL_W;
  localparam int unsigned QX_LSB      = VALUE_LSB + CELL_W;
  localparam int unsigned QY_LSB      = QX_LSB + COORD_W;
  localparam int unsigned S_PAYLOAD_W = QY_LSB + COORD_W;
  localparam int unsigned S_TDATA_W   = ((S_PAYLOAD_W + 7) / 8) * 8;

  // output tdata layout
  localparam int unsigned COST_LSB    = 0;
  localparam int unsigned GX_LSB      = COST_LSB + COST_W;
  localparam int unsigned GY_LSB      = GX_LSB + GRAD_W;
  localparam int unsigned M_PAYLOAD_W = GY_LSB + GRAD_W;
  localparam int unsigned M_TDATA_W   = ((M_PAYLOAD_W + 7) / 8) * 8;

  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CELL_W-1:0] CELL_OUTSIDE = 8'd255;

  localparam logic signed [GACC_W-1:0] GRAD_POS_LIM = 14'sd4095;
  localparam logic signed [GACC_W-1:0] GRAD_NEG_LIM = -14'sd4095;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_QUERY_OK     = 2'd0,
    ST_QUERY_OUT    = 2'd1,
    ST_WRITE_DONE   = 2'd2,
    ST_WRITE_REJECT = 2'd3
  } status_e;

endpackage

[src/cgs_ram.sv]
// ----------------------------------------------------------------------------
// cgs_ram: generic single-port ram
// one access per cycle, read-first, registered read data
// ----------------------------------------------------------------------------
module cgs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/cost_grid_bilinear_gradient_sampler.sv]
// ----------------------------------------------------------------------------
// cost_grid_bilinear_gradient_sampler: bilinear cost lookup with gradient
// byte-per-cell cost grid in one single-port ram, loaded by write
// transactions and sampled by query transactions
// ----------------------------------------------------------------------------
// A write transaction (tuser = 0) stores one cost byte and answers with
// status write done, or write rejected without storing when the cell lies
// outside the configured grid size. A query transaction (tuser = 1) reads
// 4 + 4*GRAD_SAMPLES cells from the grid ram, one per cycle, since the ram
// has a single port: four cells for the bilinear sum and four per gradient
// offset. Reads pass through a registered weight stage, a registered
// multiply stage and an accumulator. One item is worked on at a time; the
// result sits in an output register, so the next item is accepted while
// the previous result waits. Cells outside the grid read as 255, a point
// outside the grid returns 255 scaled and status query outside, and the
// gradient is always computed. Cells never written read undefined values;
// there is no clearing pass. The user must see that grid_width and grid_height
// are written only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module cost_grid_bilinear_gradient_sampler #(
  parameter int unsigned MAX_DIM      = cgs_pkg::MAX_DIM_DEF,
  parameter int unsigned FRAC_BITS    = cgs_pkg::FRAC_BITS_DEF,
  parameter int unsigned GRAD_SAMPLES = cgs_pkg::GRAD_SAMPLES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [cgs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cgs_pkg::CFG_W-1:0]      cfg_data_i,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // cell_col, cell_row, cell_value, query_x, query_y
  input  logic [cgs_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // action
  input  logic                           s_axis_tuser,
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // cost_scaled, grad_x_num, grad_y_num
  output logic [cgs_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // status
  output logic [cgs_pkg::STATUS_W-1:0]   m_axis_tuser
);

  import cgs_pkg::*;

  // ram addressing: row in the upper bits, column in the lower bits
  localparam int unsigned DB    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned AW    = 2 * DB;
  localparam int unsigned DEPTH = 1 << AW;

  // cell coordinate width and a compare width that also holds the grid size
  localparam int unsigned PW = COORD_W - FRAC_BITS + 2;
  localparam int unsigned CW = (PW > 12) ? PW : 12;

  // read schedule: four bilinear cells, then four cells per gradient offset
  localparam int unsigned NSTEP = 4 + 4 * GRAD_SAMPLES;
  localparam int unsigned SW    = $clog2(NSTEP);
  localparam logic [SW-1:0] LAST_STEP = SW'(NSTEP - 1);
  localparam logic [SW-1:0] GRAD_STEP = SW'(4);

  // cost weights are kept modulo the output width
  localparam int unsigned PRODW = (2 * FRAC_BITS + 2 > COST_W) ? 2 * FRAC_BITS + 2 : COST_W;
  localparam logic [63:0]       COST_OUT_FULL = 64'd255 << (2 * FRAC_BITS);
  localparam logic [COST_W-1:0] COST_OUT      = COST_OUT_FULL[COST_W-1:0];
  localparam logic [FRAC_BITS:0] ONE_F = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  // gradient weights 36 / (2 * i * GRAD_SAMPLES), truncated
  localparam int unsigned WBASE = 36 / (2 * GRAD_SAMPLES);
  localparam logic [WG_W-1:0] GW1 = WG_W'(WBASE);
  localparam logic [WG_W-1:0] GW2 = WG_W'(WBASE / 2);
  localparam logic [WG_W-1:0] GW3 = WG_W'(WBASE / 3);

  localparam logic signed [CW-1:0] ONE_C  = CW'(1);
  localparam logic signed [CW-1:0] ZERO_C = '0;
  localparam logic signed [CW-1:0] MAX_C  = CW'(MAX_DIM);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_OUT  = 3'b100
  } state_e;

  typedef enum logic [1:0] {
    KIND_COST = 2'd0,
    KIND_GX   = 2'd1,
    KIND_GY   = 2'd2
  } kind_e;

  // control state
  state_e               state_q, state_d;
  logic [CFG_W-1:0]     cfg_w_q, cfg_w_d;
  logic [CFG_W-1:0]     cfg_h_q, cfg_h_d;
  logic                 iss_q, iss_d;
  logic [SW-1:0]        step_q, step_d;
  logic                 s1_vld_q, s1_vld_d;
  logic                 s1_last_q, s1_last_d;
  logic                 p2_vld_q, p2_vld_d;
  logic                 p2_last_q, p2_last_d;
  logic                 m_valid_q, m_valid_d;

  // query context
  logic [FRAC_BITS-1:0] fx_q, fx_d, fy_q, fy_d;
  logic signed [PW-1:0] x0_q, x0_d, y0_q, y0_d;
  logic signed [PW-1:0] cx_q, cx_d, cy_q, cy_d;
  status_e              status_q, status_d;

  // pipeline payload
  kind_e                s1_kind_q, s1_kind_d;
  logic                 s1_neg_q, s1_neg_d;
  logic                 s1_in_q, s1_in_d;
  logic [COST_W-1:0]    s1_wc_q, s1_wc_d;
  logic [WG_W-1:0]      s1_wg_q, s1_wg_d;
  kind_e                p2_kind_q, p2_kind_d;
  logic [COST_W-1:0]    p2_cost_q, p2_cost_d;
  logic signed [GACC_W-1:0] p2_grad_q, p2_grad_d;

  // accumulators and output register
  logic [COST_W-1:0]        acc_cost_q, acc_cost_d;
  logic signed [GACC_W-1:0] acc_gx_q, acc_gx_d;
  logic signed [GACC_W-1:0] acc_gy_q, acc_gy_d;
  logic [M_TDATA_W-1:0]     m_data_q, m_data_d;
  logic [STATUS_W-1:0]      m_user_q, m_user_d;

  // input unpacking
  logic                     in_act;
  logic [CELL_W-1:0]        in_col, in_row, in_value;
  logic signed [COORD_W-1:0] in_qx, in_qy;

  assign in_act   = s_axis_tuser;
  assign in_col   = s_axis_tdata[COL_LSB +: CELL_W];
  assign in_row   = s_axis_tdata[ROW_LSB +: CELL_W];
  assign in_value = s_axis_tdata[VALUE_LSB +: CELL_W];
  assign in_qx    = $signed(s_axis_tdata[QX_LSB +: COORD_W]);
  assign in_qy    = $signed(s_axis_tdata[QY_LSB +: COORD_W]);

  // grid size in use, saturated to the ram size
  logic signed [CW-1:0] w_raw, h_raw, w_eff, h_eff;

  assign w_raw = $signed(CW'(cfg_w_q));
  assign h_raw = $signed(CW'(cfg_h_q));
  assign w_eff = (w_raw > MAX_C) ? MAX_C : w_raw;
  assign h_eff = (h_raw > MAX_C) ? MAX_C : h_raw;

  logic s_fire;
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // write decode
  logic signed [CW-1:0] wr_col, wr_row;
  logic                 wr_ok;
  logic [AW-1:0]        wr_addr;

  assign wr_col  = $signed(CW'(in_col));
  assign wr_row  = $signed(CW'(in_row));
  assign wr_ok   = (wr_col < w_eff) && (wr_row < h_eff);
  assign wr_addr = {wr_row[DB-1:0], wr_col[DB-1:0]};

  // query decode at acceptance: floor and truncation toward zero
  logic signed [PW-1:0] qx_fl, qy_fl, qx_tz, qy_tz;
  logic [FRAC_BITS-1:0] qx_fr, qy_fr;
  logic signed [CW-1:0] qx0_c, qy0_c;
  logic                 q_in_x, q_in_y;

  assign qx_fr = in_qx[FRAC_BITS-1:0];
  assign qy_fr = in_qy[FRAC_BITS-1:0];
  assign qx_fl = PW'(in_qx >>> FRAC_BITS);
  assign qy_fl = PW'(in_qy >>> FRAC_BITS);
  assign qx_tz = (in_qx[COORD_W-1] && (qx_fr != '0)) ? qx_fl + PW'(1) : qx_fl;
  assign qy_tz = (in_qy[COORD_W-1] && (qy_fr != '0)) ? qy_fl + PW'(1) : qy_fl;
  assign qx0_c = CW'(qx_fl);
  assign qy0_c = CW'(qy_fl);

  // inside when 0 <= q <= size-1 in fixed point
  assign q_in_x = !in_qx[COORD_W-1] && (qx0_c < w_eff) &&
                  ((qx0_c + ONE_C < w_eff) || (qx_fr == '0));
  assign q_in_y = !in_qy[COORD_W-1] && (qy0_c < h_eff) &&
                  ((qy0_c + ONE_C < h_eff) || (qy_fr == '0));

  // read schedule decode
  logic                 is_bil;
  logic [SW-1:0]        g_step;
  logic [1:0]           g_idx, g_sub;
  logic signed [CW-1:0] g_off;
  logic signed [CW-1:0] x0_c, y0_c, cx_c, cy_c;
  logic signed [CW-1:0] rd_col, rd_row;
  logic                 rd_in;
  logic [AW-1:0]        rd_addr;
  kind_e                rd_kind;
  logic                 rd_neg;
  logic [WG_W-1:0]      rd_wg;
  logic [FRAC_BITS:0]   wa, wb;
  logic [PRODW-1:0]     wprod;

  assign is_bil = (step_q < GRAD_STEP);
  assign g_step = step_q - GRAD_STEP;
  assign g_idx  = 2'(g_step >> 2);
  assign g_sub  = g_step[1:0];
  assign g_off  = $signed(CW'(g_idx)) + ONE_C;
  assign x0_c   = CW'(x0_q);
  assign y0_c   = CW'(y0_q);
  assign cx_c   = CW'(cx_q);
  assign cy_c   = CW'(cy_q);

  always_comb begin
    rd_kind = KIND_COST;
    rd_neg  = 1'b0;
    rd_col  = x0_c;
    rd_row  = y0_c;
    if (is_bil) begin
      rd_col = step_q[0] ? x0_c + ONE_C : x0_c;
      rd_row = step_q[1] ? y0_c + ONE_C : y0_c;
    end else begin
      unique case (g_sub)
        2'd0: begin
          rd_kind = KIND_GX;
          rd_col  = cx_c + g_off;
          rd_row  = cy_c;
        end
        2'd1: begin
          rd_kind = KIND_GX;
          rd_neg  = 1'b1;
          rd_col  = cx_c - g_off;
          rd_row  = cy_c;
        end
        2'd2: begin
          rd_kind = KIND_GY;
          rd_col  = cx_c;
          rd_row  = cy_c + g_off;
        end
        default: begin
          rd_kind = KIND_GY;
          rd_neg  = 1'b1;
          rd_col  = cx_c;
          rd_row  = cy_c - g_off;
        end
      endcase
    end
  end

  always_comb begin
    unique case (g_idx)
      2'd0:    rd_wg = GW1;
      2'd1:    rd_wg = GW2;
      default: rd_wg = GW3;
    endcase
  end

  assign rd_in   = (rd_col >= ZERO_C) && (rd_row >= ZERO_C) &&
                   (rd_col < w_eff) && (rd_row < h_eff);
  assign rd_addr = {rd_row[DB-1:0], rd_col[DB-1:0]};

  // bilinear weight of the cell being read
  assign wa    = step_q[0] ? {1'b0, fx_q} : ONE_F - {1'b0, fx_q};
  assign wb    = step_q[1] ? {1'b0, fy_q} : ONE_F - {1'b0, fy_q};
  assign wprod = PRODW'(wa) * PRODW'(wb);

  // grid ram: writes from idle, reads while issuing
  logic              ram_en, ram_we;
  logic [AW-1:0]     ram_addr;
  logic [CELL_W-1:0] ram_rdata;

  assign ram_we   = s_fire && (in_act == ACT_WRITE) && wr_ok;
  assign ram_en   = ram_we || iss_q;
  assign ram_addr = (state_q == S_IDLE) ? wr_addr : rd_addr;

  cgs_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (in_value),
    .rdata_o (ram_rdata)
  );

  // multiply stage operands
  logic [CELL_W-1:0]        cell_val;
  logic [COST_W+CELL_W-1:0] cost_prod;
  logic [GACC_W-1:0]        grad_mag;

  assign cell_val  = s1_in_q ? ram_rdata : CELL_OUTSIDE;
  assign cost_prod = (COST_W + CELL_W)'(cell_val) * (COST_W + CELL_W)'(s1_wc_q);
  assign grad_mag  = GACC_W'(s1_wg_q) * GACC_W'(cell_val);

  // output formatting with saturated gradients
  logic [COST_W-1:0]        out_cost;
  logic signed [GACC_W-1:0] gx_sat, gy_sat;

  assign out_cost = (status_q == ST_QUERY_OUT) ? COST_OUT : acc_cost_q;
  assign gx_sat   = (acc_gx_q > GRAD_POS_LIM) ? GRAD_POS_LIM :
                    (acc_gx_q < GRAD_NEG_LIM) ? GRAD_NEG_LIM : acc_gx_q;
  assign gy_sat   = (acc_gy_q > GRAD_POS_LIM) ? GRAD_POS_LIM :
                    (acc_gy_q < GRAD_NEG_LIM) ? GRAD_NEG_LIM : acc_gy_q;

  always_comb begin
    state_d    = state_q;
    cfg_w_d    = cfg_w_q;
    cfg_h_d    = cfg_h_q;
    iss_d      = iss_q;
    step_d     = step_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    fx_d       = fx_q;
    fy_d       = fy_q;
    x0_d       = x0_q;
    y0_d       = y0_q;
    cx_d       = cx_q;
    cy_d       = cy_q;
    status_d   = status_q;
    acc_cost_d = acc_cost_q;
    acc_gx_d   = acc_gx_q;
    acc_gy_d   = acc_gy_q;
    m_data_d   = m_data_q;
    m_user_d   = m_user_q;

    // three-stage read pipeline: issue, multiply, accumulate
    s1_vld_d   = iss_q;
    s1_last_d  = iss_q && (step_q == LAST_STEP);
    s1_kind_d  = rd_kind;
    s1_neg_d   = rd_neg;
    s1_in_d    = rd_in;
    s1_wc_d    = wprod[COST_W-1:0];
    s1_wg_d    = rd_wg;
    p2_vld_d   = s1_vld_q;
    p2_last_d  = s1_last_q;
    p2_kind_d  = s1_kind_q;
    p2_cost_d  = cost_prod[COST_W-1:0];
    p2_grad_d  = s1_neg_q ? -$signed(grad_mag) : $signed(grad_mag);

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRID_WIDTH: cfg_w_d = cfg_data_i;
        default:        cfg_h_d = cfg_data_i;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          acc_cost_d = '0;
          acc_gx_d   = '0;
          acc_gy_d   = '0;
          if (in_act == ACT_QUERY) begin
            fx_d     = qx_fr;
            fy_d     = qy_fr;
            x0_d     = qx_fl;
            y0_d     = qy_fl;
            cx_d     = qx_tz;
            cy_d     = qy_tz;
            status_d = (q_in_x && q_in_y) ? ST_QUERY_OK : ST_QUERY_OUT;
            iss_d    = 1'b1;
            step_d   = '0;
            state_d  = S_RUN;
          end else begin
            status_d = wr_ok ? ST_WRITE_DONE : ST_WRITE_REJECT;
            state_d  = S_OUT;
          end
        end
      end
      S_RUN: begin
        if (iss_q) begin
          step_d = step_q + SW'(1);
          if (step_q == LAST_STEP) begin
            iss_d = 1'b0;
          end
        end
        if (p2_vld_q) begin
          unique case (p2_kind_q)
            KIND_COST: acc_cost_d = acc_cost_q + p2_cost_q;
            KIND_GX:   acc_gx_d   = acc_gx_q + p2_grad_q;
            default:   acc_gy_d   = acc_gy_q + p2_grad_q;
          endcase
        end
        if (p2_last_q) begin
          state_d = S_OUT;
        end
      end
      default: begin
        // output register frees up or is already empty
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = M_TDATA_W'({gy_sat[GRAD_W-1:0], gx_sat[GRAD_W-1:0], out_cost});
          m_user_d  = status_q;
          state_d   = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cfg_w_q   <= 9'd256;
      cfg_h_q   <= 9'd256;
      iss_q     <= 1'b0;
      step_q    <= '0;
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
      p2_vld_q  <= 1'b0;
      p2_last_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cfg_w_q   <= cfg_w_d;
      cfg_h_q   <= cfg_h_d;
      iss_q     <= iss_d;
      step_q    <= step_d;
      s1_vld_q  <= s1_vld_d;
      s1_last_q <= s1_last_d;
      p2_vld_q  <= p2_vld_d;
      p2_last_q <= p2_last_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fx_q       <= fx_d;
    fy_q       <= fy_d;
    x0_q       <= x0_d;
    y0_q       <= y0_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    status_q   <= status_d;
    s1_kind_q  <= s1_kind_d;
    s1_neg_q   <= s1_neg_d;
    s1_in_q    <= s1_in_d;
    s1_wc_q    <= s1_wc_d;
    s1_wg_q    <= s1_wg_d;
    p2_kind_q  <= p2_kind_d;
    p2_cost_q  <= p2_cost_d;
    p2_grad_q  <= p2_grad_d;
    acc_cost_q <= acc_cost_d;
    acc_gx_q   <= acc_gx_d;
    acc_gy_q   <= acc_gy_d;
    m_data_q   <= m_data_d;
    m_user_q   <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the bilinear cost grid sampler
// loads cost cells through write transactions, samples the grid with query
// transactions and checks every result against an in-bench predictor that
// keeps its own copy of the grid and of the size registers
// ----------------------------------------------------------------------------
module tb;
  import cgs_pkg::*;

  localparam int FRAC  = FRAC_BITS_DEF;
  localparam int DIM   = MAX_DIM_DEF;
  localparam int NGRAD = GRAD_SAMPLES_DEF;
  localparam int ONE   = 1 << FRAC;
  // query latency of the block plus some margin
  localparam int SETTLE_CYCLES = 4 * NGRAD + 16;
  localparam int IDLE_PCT      = 28;

  typedef struct {
    action_e                   act;
    logic [CELL_W-1:0]         col;
    logic [CELL_W-1:0]         row;
    logic [CELL_W-1:0]         value;
    logic signed [COORD_W-1:0] qx;
    logic signed [COORD_W-1:0] qy;
  } grid_req_t;

  typedef struct {
    logic [COST_W-1:0]        cost;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    status_e                  st;
  } grid_res_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // cell_col, cell_row, cell_value, query_x, query_y
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  // action
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // cost_scaled, grad_x_num, grad_y_num
  logic [M_TDATA_W-1:0] m_axis_tdata;
  // status
  logic [STATUS_W-1:0]  m_axis_tuser;

  // predictor state: grid contents, which cells were ever written, size registers
  logic [CELL_W-1:0] grid_cells [DIM*DIM];
  bit                cell_known [DIM*DIM];
  int unsigned       reg_width = DIM;
  int unsigned       reg_height = DIM;

  grid_res_t   pending_results[$];
  int unsigned error_count, result_count;
  int unsigned n_writes, n_rejects, n_queries, n_outside, n_cfg;
  bit          steady;       // no idling on either side while set
  int unsigned hold_cycles;  // receiver hold-off, counted down by the monitor

  always #5 clk_i = ~clk_i;

  cost_grid_bilinear_gradient_sampler u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  // size registers above the maximum saturate
  function automatic int eff_dim(int unsigned v);
    return (v > DIM) ? DIM : int'(v);
  endfunction

  // cells off the grid read as 255
  function automatic int cell_at(int c, int r);
    if (c < 0 || r < 0 || c >= eff_dim(reg_width) || r >= eff_dim(reg_height)) return 255;
    return int'(grid_cells[r*DIM + c]);
  endfunction

  // fixed point to cell index, rounding toward zero
  function automatic int trunc_cell(int q);
    return (q >= 0) ? (q >>> FRAC) : -((-q) >>> FRAC);
  endfunction

  // expected result of one transaction; a write also updates the grid copy
  function automatic grid_res_t grid_response(grid_req_t rq);
    grid_res_t rs;
    int w, h, qx, qy, x0, y0, fx, fy, cx, cy, wt, gx, gy, acc;
    w = eff_dim(reg_width);
    h = eff_dim(reg_height);
    rs.cost = '0;
    rs.gx = '0;
    rs.gy = '0;
    if (rq.act == ACT_WRITE) begin
      if (rq.col < w && rq.row < h) begin
        grid_cells[rq.row*DIM + rq.col] = rq.value;
        cell_known[rq.row*DIM + rq.col] = 1'b1;
        rs.st = ST_WRITE_DONE;
      end else begin
        rs.st = ST_WRITE_REJECT;
      end
      return rs;
    end
    qx = rq.qx;
    qy = rq.qy;
    if (qx >= 0 && qy >= 0 && qx + ONE <= w * ONE && qy + ONE <= h * ONE) begin
      x0 = qx >>> FRAC;
      y0 = qy >>> FRAC;
      fx = qx & (ONE - 1);
      fy = qy & (ONE - 1);
      // right or bottom neighbour may be off the grid, its weight is then zero
      acc = (ONE - fx) * (ONE - fy) * cell_at(x0, y0)
          + fx * (ONE - fy) * cell_at(x0 + 1, y0)
          + (ONE - fx) * fy * cell_at(x0, y0 + 1)
          + fx * fy * cell_at(x0 + 1, y0 + 1);
      rs.cost = COST_W'(acc);
      rs.st = ST_QUERY_OK;
    end else begin
      rs.cost = COST_W'(255 << (2 * FRAC));
      rs.st = ST_QUERY_OUT;
    end
    // central differences, computed for outside points too
    cx = trunc_cell(qx);
    cy = trunc_cell(qy);
    gx = 0;
    gy = 0;
    for (int i = 1; i <= NGRAD; i++) begin
      wt = (36 / (2 * NGRAD)) / i;
      gx += wt * (cell_at(cx + i, cy) - cell_at(cx - i, cy));
      gy += wt * (cell_at(cx, cy + i) - cell_at(cx, cy - i));
    end
    if (gx > 4095) gx = 4095;
    if (gx < -4095) gx = -4095;
    if (gy > 4095) gy = 4095;
    if (gy < -4095) gy = -4095;
    rs.gx = GRAD_W'(gx);
    rs.gy = GRAD_W'(gy);
    return rs;
  endfunction

  // --------------------------------------------------------------------------
  // result side
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    if (error_count <= 50)
      $display("tb: mismatch in %s at %0t ns: got %0d, want %0d", what, $time, got, want);
  endtask

  task automatic check_result();
    grid_res_t                want;
    logic [COST_W-1:0]        cost;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    cost = m_axis_tdata[COST_LSB +: COST_W];
    gx = m_axis_tdata[GX_LSB +: GRAD_W];
    gy = m_axis_tdata[GY_LSB +: GRAD_W];
    result_count++;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing pending, status", m_axis_tuser, 0);
      return;
    end
    want = pending_results.pop_front();
    if (cost !== want.cost) report_mismatch("cost_scaled", cost, want.cost);
    if (gx !== want.gx) report_mismatch("grad_x_num", gx, want.gx);
    if (gy !== want.gy) report_mismatch("grad_y_num", gy, want.gy);
    if (m_axis_tuser !== want.st) report_mismatch("status", m_axis_tuser, want.st);
  endtask

  // sample at the rising edge, change tready at the falling edge
  initial begin : result_monitor
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) check_result();
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------

  function automatic grid_req_t random_req(action_e act);
    grid_req_t rq;
    // unused fields carry random bits too
    rq.act = act;
    rq.col = CELL_W'($urandom);
    rq.row = CELL_W'($urandom);
    rq.value = CELL_W'($urandom);
    rq.qx = COORD_W'($urandom);
    rq.qy = COORD_W'($urandom);
    return rq;
  endfunction

  // offer one transaction and record its expected result once it is taken
  task automatic send_item(grid_req_t rq);
    logic [S_TDATA_W-1:0] word;
    grid_res_t            rs;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    word = '0;
    word[COL_LSB +: CELL_W] = rq.col;
    word[ROW_LSB +: CELL_W] = rq.row;
    word[VALUE_LSB +: CELL_W] = rq.value;
    word[QX_LSB +: COORD_W] = rq.qx;
    word[QY_LSB +: COORD_W] = rq.qy;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= rq.act;
    s_axis_tdata <= word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    rs = grid_response(rq);
    pending_results.push_back(rs);
    case (rs.st)
      ST_WRITE_DONE:   n_writes++;
      ST_WRITE_REJECT: begin
        n_writes++;
        n_rejects++;
      end
      ST_QUERY_OUT:    begin
        n_queries++;
        n_outside++;
      end
      default:         n_queries++;
    endcase
  endtask

  task automatic send_write(int col, int row, int value);
    grid_req_t rq;
    rq = random_req(ACT_WRITE);
    rq.col = CELL_W'(col);
    rq.row = CELL_W'(row);
    rq.value = CELL_W'(value);
    send_item(rq);
  endtask

  // cells never written hold undefined data, so every grid cell that a query
  // may touch is loaded first: the bilinear square around the floor and the
  // truncated cell, and the gradient cross
  task automatic prime_cells(int qx, int qy);
    int bx[2], by[2];
    int c, r;
    bx[0] = qx >>> FRAC;
    by[0] = qy >>> FRAC;
    bx[1] = trunc_cell(qx);
    by[1] = trunc_cell(qy);
    for (int k = 0; k < 2; k++)
      for (int dc = -NGRAD; dc <= NGRAD + 1; dc++)
        for (int dr = -NGRAD; dr <= NGRAD + 1; dr++) begin
          c = bx[k] + dc;
          r = by[k] + dr;
          if (((dc >= 0 && dc <= 1 && dr >= 0 && dr <= 1) || dc == 0 || dr == 0) &&
              c >= 0 && r >= 0 && c < eff_dim(reg_width) && r < eff_dim(reg_height) &&
              !cell_known[r*DIM + c])
            send_write(c, r, $urandom_range(0, 255));
        end
  endtask

  task automatic send_query(int qx, int qy);
    grid_req_t rq;
    prime_cells(qx, qy);
    rq = random_req(ACT_QUERY);
    rq.qx = COORD_W'(qx);
    rq.qy = COORD_W'(qy);
    send_item(rq);
  endtask

  // stop offering, wait for every pending result and let the block settle
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_idx_e idx, int unsigned value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CFG_W'(value);
    @(posedge clk_i);
    if (idx == CFG_GRID_WIDTH) reg_width = value & 'h1FF;
    else reg_height = value & 'h1FF;
    n_cfg++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // size changes only with the block idle
  task automatic set_grid(int unsigned w, int unsigned h);
    drain_results();
    write_register(CFG_GRID_WIDTH, w);
    write_register(CFG_GRID_HEIGHT, h);
  endtask

  task automatic fill_grid(int w, int h);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) send_write(c, r, $urandom_range(0, 255));
  endtask

  // query coordinate along a grid side of n cells, biased to the edges
  function automatic int pick_coord(int n);
    case ($urandom_range(5))
      0:       return $urandom_range(0, (n - 1) * ONE);
      1:       return $urandom_range(0, n - 1) * ONE;
      2:       return (n - 1) * ONE;
      3:       return (n - 1) * ONE + $urandom_range(1, 2 * ONE);
      4:       return -int'($urandom_range(1, 2 * ONE));
      default: return int'($urandom_range(0, 2**COORD_W - 1)) - 2**(COORD_W - 1);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // full size after reset: corner cells, exact far corner, field extremes
  task automatic test_full_size_edges();
    send_write(0, 0, 0);
    send_write(255, 255, 255);
    send_query(255 * ONE, 255 * ONE);
    send_query(0, 0);
    send_query(ONE / 2, ONE / 2);
    send_query(255 * ONE + 1, 2 * ONE);
    send_query(-131072, 131071);
    send_query(131071, -131072);
  endtask

  // 3x2 grid: interior, edges, just outside, small negative points, rejects
  task automatic test_small_grid();
    set_grid(3, 2);
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 3; c++) send_write(c, r, (r * 3 + c) * 51);
    send_write(3, 0, 17);
    send_write(0, 2, 17);
    send_write(255, 255, 17);
    send_query(ONE + ONE / 2, ONE / 4);
    send_query(2 * ONE, ONE);
    send_query(ONE / 2, ONE - 1);
    send_query(2 * ONE + 1, 0);
    send_query(-1, -1);
  endtask

  // empty grid, saturating size, one by one grid
  task automatic test_register_extremes();
    set_grid(0, DIM);
    send_write(0, 0, 99);
    send_query(0, 0);
    set_grid(511, 1);
    send_write(255, 0, 200);
    send_query(ONE, 0);
    send_query(255 * ONE, 0);
    set_grid(1, 1);
    send_query(0, 0);
    send_query(0, ONE / 2);
    set_grid(DIM, 0);
    send_write(0, 0, 1);
    send_query(ONE, ONE);
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    set_grid(4, 4);
    fill_grid(4, 4);
    drain_results();
    hold_cycles = 200;
    repeat (12) send_query(pick_coord(4), pick_coord(4));
  endtask

  // several small grids, fully loaded, then mixed writes and queries
  task automatic test_random_small_grids();
    int w, h;
    for (int p = 0; p < 4; p++) begin
      w = (p == 0) ? 1 : $urandom_range(1, 8);
      h = (p == 3) ? 8 : $urandom_range(1, 8);
      set_grid(w, h);
      steady = (p == 1);
      fill_grid(w, h);
      repeat (40) begin
        case ($urandom_range(7))
          0:       send_write($urandom_range(0, w - 1), $urandom_range(0, h - 1),
                              $urandom_range(0, 255));
          1:       send_write($urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 255));
          default: send_query(pick_coord(w), pick_coord(h));
        endcase
      end
      steady = 1'b0;
    end
  endtask

  // full size grid: random writes and queries, mostly around the top-left and bottom-right corners
  task automatic test_random_full_corners();
    int e;
    set_grid(DIM, DIM);
    repeat (40) begin
      e = $urandom_range(1) ? DIM - 1 : 0;
      case ($urandom_range(7))
        0:       send_write($urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255));
        1:       send_query(pick_coord(DIM), pick_coord(DIM));
        default: send_query(e * ONE + $urandom_range(0, 4 * ONE) - 2 * ONE,
                            e * ONE + $urandom_range(0, 4 * ONE) - 2 * ONE);
      endcase
    end
  endtask

  initial begin : run
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_full_size_edges();
    test_small_grid();
    test_register_extremes();
    test_backpressure();
    test_random_small_grids();
    test_random_full_corners();
    drain_results();
    $display("tb: %0d cell writes (%0d rejected), %0d queries (%0d outside the grid)",
             n_writes, n_rejects, n_queries, n_outside);
    $display("tb: %0d size register writes, %0d results checked, %0d mismatches",
             n_cfg, result_count, error_count);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
